/* hw/rtl/adts_pkg.sv */
package adts_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 13;
  localparam int HLEN_W = 4;
  localparam int HDR_BYTES = 7;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);

  // Fixed ADTS header fields.
  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC_NIB_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] PROT_MASK     = 8'h01;
  localparam logic [BYTE_W-1:0] LEN_HI_MASK   = 8'h03;
  localparam logic [BYTE_W-1:0] LEN_LO_MASK   = 8'hE0;

  localparam logic [HLEN_W-1:0] HLEN_NO_CRC = 4'd7;
  localparam logic [HLEN_W-1:0] HLEN_CRC    = 4'd9;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 13'd2048;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr_vec_t;

  // Decoded view of a complete header.
  typedef struct packed {
    logic              ok;
    logic              empty;
    logic [LEN_W-1:0]  flen;
    logic [HLEN_W-1:0] hlen;
    logic [LEN_W-1:0]  pay_len;
  } hdr_info_t;

endpackage

/* hw/rtl/adts_in_if.sv */
interface adts_in_if;
  import adts_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* hw/rtl/adts_out_if.sv */
interface adts_out_if;
  import adts_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last;
  logic  unframed;

  modport source (output valid, output out_byte, output last, output unframed, input ready);
  modport sink (input valid, input out_byte, input last, input unframed, output ready);
endinterface

/* hw/rtl/adts_frame_deframer.sv */
// ADTS frame deframer.
// The input channel in_ch carries one byte of an ADTS stream per transfer. The block
// gathers the seven fixed header bytes, checks the sync word and reads the
// protection-absent bit and the frame length. Payload bytes then leave on out_ch,
// cut to the limit written through cfg_we / cfg_wdata, with last on the final byte.
// CRC bytes and payload bytes past the limit are dropped.
// A header with a bad sync word or a too-short length is replayed as seven output
// transfers marked unframed, last on the seventh, and hunting starts over.
// A payload byte taken from in_ch is shown on out_ch in the next cycle, from the output register.
// Throughput is one byte per cycle unless the receiver stalls; beside stalls, the only
// gap is the replay of a bad header, which holds in_ch.ready low after the seventh
// header byte while the store is read out, one entry per cycle barring stalls.
// A single output register sits between the channels: the block keeps taking bytes
// while a result waits, as long as the receiver takes it in the same cycle.
// When the receiver stalls, the output register holds and in_ch.ready drops.
// Reset (rst_n low, synchronous) empties the output register, restarts hunting and
// sets the payload limit to 2048 bytes.
module adts_frame_deframer (
  input  logic                    clk,
  input  logic                    rst_n,
  adts_in_if.sink                 in_ch,
  adts_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [adts_pkg::LEN_W-1:0] cfg_wdata
);
  import adts_pkg::*;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;

  localparam logic [HDR_IDX_W-1:0] LAST_HDR_IDX = HDR_IDX_W'(HDR_BYTES - 1);
  localparam logic [LEN_W-1:0]     HDR_BYTES_L  = LEN_W'(HDR_BYTES);

  // Header bytes; written before they are read in every hunt, so no reset.
  byte_t hdr_r [HDR_BYTES];

  logic [1:0]        phase_r, phase_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  flen_r, flen_nxt;
  logic [HLEN_W-1:0] hlen_r, hlen_nxt;
  logic [LEN_W-1:0]  pay_len_r, pay_len_nxt;
  logic [LEN_W-1:0]  max_r;

  logic                 replay_r, replay_nxt;
  logic [HDR_IDX_W-1:0] rp_idx_r, rp_idx_nxt;

  logic  ov_r, ov_nxt;
  byte_t ob_r, ob_nxt;
  logic  ol_r, ol_nxt;
  logic  ou_r, ou_nxt;

  logic                 slot_free;
  logic                 acc;
  logic [HDR_IDX_W-1:0] wr_idx;
  hdr_vec_t             hdr_vec;
  hdr_info_t            info;

  logic [LEN_W-1:0] pos_off;
  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] cnt_inc;
  logic             emit;

  assign slot_free   = !ov_r || out_ch.ready;
  assign in_ch.ready = !replay_r && slot_free;
  assign acc         = in_ch.valid && in_ch.ready;

  // Slot for the incoming header byte; a stale count past the header starts over.
  assign wr_idx = (cnt_r >= HDR_BYTES_L) ? '0 : cnt_r[HDR_IDX_W-1:0];

  // The last header byte is checked straight from the input, the rest from the store.
  always_comb begin
    for (int k = 0; k < HDR_BYTES - 1; k++) begin
      hdr_vec[k] = hdr_r[k];
    end
    hdr_vec[HDR_BYTES-1] = in_ch.in_byte;
  end

  adts_hdr_check u_hdr_check (
    .hdr  (hdr_vec),
    .info (info)
  );

  // Body bookkeeping: offset into the payload and the number of bytes to pass.
  assign pos_off = cnt_r - {{(LEN_W-HLEN_W){1'b0}}, hlen_r};
  assign lim     = (pay_len_r > max_r) ? max_r : pay_len_r;
  assign cnt_inc = cnt_r + LEN_W'(1);
  assign emit    = (cnt_r >= {{(LEN_W-HLEN_W){1'b0}}, hlen_r}) && (pos_off < lim);

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    flen_nxt    = flen_r;
    hlen_nxt    = hlen_r;
    pay_len_nxt = pay_len_r;
    replay_nxt  = replay_r;
    rp_idx_nxt  = rp_idx_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    ou_nxt      = ou_r;

    if (acc) begin
      if (phase_r != PH_BODY) begin
        if (wr_idx != LAST_HDR_IDX) begin
          cnt_nxt = LEN_W'(wr_idx) + LEN_W'(1);
        end else if (!info.ok) begin
          // Bad header: first replayed byte goes out now, the rest follow.
          cnt_nxt    = '0;
          phase_nxt  = PH_HEADER;
          ov_nxt     = 1'b1;
          ob_nxt     = hdr_r[0];
          ol_nxt     = 1'b0;
          ou_nxt     = 1'b1;
          replay_nxt = 1'b1;
          rp_idx_nxt = HDR_IDX_W'(1);
        end else if (info.empty) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HEADER;
        end else begin
          flen_nxt    = info.flen;
          hlen_nxt    = info.hlen;
          pay_len_nxt = info.pay_len;
          phase_nxt   = PH_BODY;
          cnt_nxt     = HDR_BYTES_L;
        end
      end else begin
        if (emit) begin
          ov_nxt = 1'b1;
          ob_nxt = in_ch.in_byte;
          ol_nxt = ((pos_off + LEN_W'(1)) == lim);
          ou_nxt = 1'b0;
        end
        cnt_nxt = cnt_inc;
        if ((cnt_inc >= flen_r) || (cnt_inc == '0)) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HEADER;
        end
      end
    end else if (replay_r && slot_free) begin
      ov_nxt     = 1'b1;
      ob_nxt     = hdr_r[rp_idx_r];
      ol_nxt     = (rp_idx_r == LAST_HDR_IDX);
      ou_nxt     = 1'b1;
      rp_idx_nxt = rp_idx_r + HDR_IDX_W'(1);
      if (rp_idx_r == LAST_HDR_IDX) begin
        replay_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (phase_r != PH_BODY)) begin
      hdr_r[wr_idx] <= in_ch.in_byte;
    end
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    ou_r <= ou_nxt;
    pay_len_r <= pay_len_nxt;
    rp_idx_r  <= rp_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      flen_r   <= '0;
      hlen_r   <= HLEN_NO_CRC;
      replay_r <= 1'b0;
      ov_r     <= 1'b0;
      max_r    <= MAX_PAYLOAD_RST;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      flen_r   <= flen_nxt;
      hlen_r   <= hlen_nxt;
      replay_r <= replay_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.last     = ol_r;
  assign out_ch.unframed = ou_r;
endmodule

/* hw/rtl/adts_hdr_check.sv */
module adts_hdr_check (
  input  adts_pkg::hdr_vec_t  hdr,
  output adts_pkg::hdr_info_t info
);
  import adts_pkg::*;

  logic [LEN_W-1:0]  flen;
  logic [HLEN_W-1:0] hlen;
  logic              sync_ok;

  // Frame length spans bytes 3 to 5 of the header.
  assign flen = {hdr[3][1:0] & LEN_HI_MASK[1:0], hdr[4], hdr[5][7:5] & LEN_LO_MASK[7:5]};
  assign hlen = ((hdr[1] & PROT_MASK) != '0) ? HLEN_NO_CRC : HLEN_CRC;
  assign sync_ok = (hdr[0] == SYNC_BYTE) && ((hdr[1] & SYNC_NIB_MASK) == SYNC_NIB_MASK);

  always_comb begin
    info.flen    = flen;
    info.hlen    = hlen;
    info.ok      = sync_ok && (flen >= {{(LEN_W-HLEN_W){1'b0}}, hlen});
    info.empty   = (flen == {{(LEN_W-HLEN_W){1'b0}}, hlen});
    info.pay_len = flen - {{(LEN_W-HLEN_W){1'b0}}, hlen};
  end
endmodule

/* hw/rtl/adts_checker.sv */
module adts_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input adts_pkg::byte_t      out_byte,
  input logic                 out_last,
  input logic                 out_unframed
);
  import adts_pkg::*;

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
      && $stable(out_unframed))
    else $error("result changed while stalled");

  // No new byte is taken while a bad header is being replayed.
  a_replay_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unframed && !out_last |-> !in_ready)
    else $error("input taken during header replay");

  // A replay runs without gaps until its last byte.
  a_replay_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_unframed && !out_last |=> out_valid && out_unframed)
    else $error("header replay interrupted");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind adts_frame_deframer adts_checker u_adts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .out_last     (out_ch.last),
  .out_unframed (out_ch.unframed)
);
